@@ src/mono_lcd_page_report_builder_unit_assert.svh @@
// assertion macros shared by the page report builder modules
// expects clk and rst_n in the scope of every use
`ifndef MONO_LCD_PAGE_REPORT_BUILDER_UNIT_ASSERT_SVH
`define MONO_LCD_PAGE_REPORT_BUILDER_UNIT_ASSERT_SVH

// consequent must hold in the same cycle
`define MLPR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// consequent must hold in the next cycle
`define MLPR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/mlpr_pkg.sv @@
// types and constants of the page report builder
// used by mlpr_ctrl, mlpr_dp and the top level; no dependencies
package mlpr_pkg;

  localparam int IDX_W    = 10;
  localparam int ADDR_W   = 10;
  localparam int BYTE_W   = 8;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_W    = 8;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_READ  = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_REPORT_ID = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_INVERT    = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_READ,
    ST_FLUSH,
    ST_OUT
  } state_t;

  typedef enum logic [1:0] {
    KIND_ZERO,
    KIND_ID,
    KIND_PIX
  } kind_t;

  typedef struct packed {
    logic wr_en;
    logic load_req;
    logic decode;
    logic rd_issue;
    logic out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic is_pixel;
    logic rd_done;
    logic out_free;
  } dp_sts_t;

endpackage

@@ src/mlpr_ctrl.sv @@
// controller of the page report builder: sequences accept, decode, the
// eight row reads of a pixel byte and output load; depends on mlpr_pkg
module mlpr_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_opcode,
  output logic                  in_stall,
  input  mlpr_pkg::dp_sts_t     sts_i,
  output mlpr_pkg::ctrl_cmd_t   cmd_o
);
  import mlpr_pkg::*;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid && in_opcode == OP_READ) begin
          state_nxt = ST_DECODE;
        end
      end
      ST_DECODE: begin
        state_nxt = sts_i.is_pixel ? ST_READ : ST_OUT;
      end
      ST_READ: begin
        if (sts_i.rd_done) begin
          state_nxt = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (sts_i.out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_stall       = 1'b1;
    cmd_o          = '0;
    case (state_r)
      ST_IDLE: begin
        in_stall       = 1'b0;
        cmd_o.wr_en    = in_valid && in_opcode == OP_WRITE;
        cmd_o.load_req = in_valid && in_opcode == OP_READ;
      end
      ST_DECODE: begin
        cmd_o.decode = 1'b1;
      end
      ST_READ: begin
        cmd_o.rd_issue = 1'b1;
      end
      ST_FLUSH: begin
        cmd_o = '0;
      end
      ST_OUT: begin
        cmd_o.out_load = sts_i.out_free;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

`include "mono_lcd_page_report_builder_unit_assert.svh"

  `MLPR_ASSERT_NEXT(a_read_decodes, cmd_o.load_req, state_r == ST_DECODE, "read request not decoded")
  `MLPR_ASSERT_NEXT(a_write_idle, cmd_o.wr_en, state_r == ST_IDLE, "write request left idle")
  `MLPR_ASSERT_NEXT(a_read_flush, cmd_o.rd_issue && sts_i.rd_done, state_r == ST_FLUSH, "row reads did not end")

endmodule

@@ src/mlpr_dp.sv @@
// datapath of the page report builder: frame store, index decode, row
// address walk, column byte assembly and output register; depends on mlpr_pkg
module mlpr_dp #(
  parameter int PanelWidth  = 160,
  parameter int PanelHeight = 43,
  parameter int HeaderBytes = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [mlpr_pkg::ADDR_W-1:0]   in_image_address,
  input  logic [mlpr_pkg::BYTE_W-1:0]   in_image_byte,
  input  logic [mlpr_pkg::IDX_W-1:0]    in_report_index,
  input  logic                          cfg_we,
  input  logic [mlpr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [mlpr_pkg::CFG_W-1:0]    cfg_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [mlpr_pkg::BYTE_W-1:0]   out_report_byte,
  output logic                          out_is_last,
  input  mlpr_pkg::ctrl_cmd_t           cmd_i,
  output mlpr_pkg::dp_sts_t             sts_o
);
  import mlpr_pkg::*;

  localparam int RowBytes   = (PanelWidth + 7) / 8;
  localparam int Pages      = (PanelHeight + 7) / 8;
  localparam int StoreDepth = PanelHeight * RowBytes;
  localparam int ReportLen  = HeaderBytes + Pages * PanelWidth;
  localparam int AW         = $clog2(StoreDepth);
  localparam int CW         = $clog2(PanelWidth);
  localparam int PGW        = (Pages > 1) ? $clog2(Pages) : 1;
  localparam int RW         = PGW + 3;

  logic [BYTE_W-1:0] mem [StoreDepth];
  logic [BYTE_W-1:0] rdata_r;

  logic [BYTE_W-1:0] report_id_r;
  logic              invert_r;

  logic [IDX_W-1:0]  idx_r;
  kind_t             kind_r;
  kind_t             kind_c;
  logic              last_r;
  logic              last_c;

  logic [PGW-1:0]    page_c;
  logic [CW-1:0]     col_c;
  logic [AW-1:0]     base_c;
  logic [CW-1:0]     col_r;
  logic [AW-1:0]     addr_r;
  logic [RW-1:0]     row_r;

  logic              row_ok;
  logic              pend_valid_r;
  logic [2:0]        pend_k_r;
  logic [BYTE_W-1:0] acc_r;

  logic              out_valid_r;
  logic [BYTE_W-1:0] out_byte_r;
  logic              out_last_r;
  logic [BYTE_W-1:0] out_byte_c;

  logic              wr_ok;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      report_id_r <= '0;
      invert_r    <= 1'b1;
    end else if (cfg_we) begin
      if (cfg_index == CFG_REPORT_ID) begin
        report_id_r <= cfg_data;
      end
      if (cfg_index == CFG_INVERT) begin
        invert_r <= cfg_data[0];
      end
    end
  end

  // frame store, one write and one registered read per cycle
  assign wr_ok  = cmd_i.wr_en && (int'(in_image_address) < StoreDepth);
  assign row_ok = int'(row_r) < PanelHeight;

  always_ff @(posedge clk) begin
    if (wr_ok) begin
      mem[AW'(in_image_address)] <= in_image_byte;
    end
    if (cmd_i.rd_issue && row_ok) begin
      rdata_r <= mem[addr_r];
    end
  end

  // index decode: kind of byte, page and column
  always_comb begin
    int p;
    p      = int'(idx_r) - HeaderBytes;
    page_c = '0;
    col_c  = CW'(p);
    base_c = '0;
    for (int k = 1; k < Pages; k++) begin
      if (p >= k * PanelWidth) begin
        page_c = PGW'(k);
        col_c  = CW'(p - k * PanelWidth);
        base_c = AW'(k * 8 * RowBytes);
      end
    end
    if (int'(idx_r) >= ReportLen) begin
      kind_c = KIND_ZERO;
    end else if (idx_r == '0) begin
      kind_c = KIND_ID;
    end else if (int'(idx_r) < HeaderBytes) begin
      kind_c = KIND_ZERO;
    end else begin
      kind_c = KIND_PIX;
    end
    last_c = int'(idx_r) == ReportLen - 1;
  end

  always_ff @(posedge clk) begin
    if (cmd_i.load_req) begin
      idx_r <= in_report_index;
    end
    if (cmd_i.decode) begin
      kind_r <= kind_c;
      last_r <= last_c;
      col_r  <= col_c;
      // first row of the page, byte holding the column
      addr_r <= AW'(base_c + AW'(col_c >> 3));
      row_r  <= {page_c, 3'b000};
      acc_r  <= '0;
    end else begin
      if (cmd_i.rd_issue) begin
        addr_r <= AW'(addr_r + AW'(RowBytes));
        row_r  <= RW'(row_r + 1'b1);
      end
      // rows beyond the panel leave their bit at zero
      if (pend_valid_r) begin
        acc_r[pend_k_r] <= rdata_r[3'd7 - col_r[2:0]];
      end
    end
    pend_k_r <= row_r[2:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_valid_r <= 1'b0;
    end else begin
      pend_valid_r <= cmd_i.rd_issue && row_ok;
    end
  end

  // output register
  always_comb begin
    case (kind_r)
      KIND_PIX: out_byte_c = invert_r ? ~acc_r : acc_r;
      KIND_ID:  out_byte_c = report_id_r;
      default:  out_byte_c = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_i.out_load) begin
      out_byte_r <= out_byte_c;
      out_last_r <= last_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_report_byte = out_byte_r;
  assign out_is_last     = out_last_r;

  assign sts_o.is_pixel = kind_c == KIND_PIX;
  assign sts_o.rd_done  = row_r[2:0] == 3'b111;
  assign sts_o.out_free = !out_valid_r || !out_stall;

`include "mono_lcd_page_report_builder_unit_assert.svh"

  `MLPR_ASSERT_NEXT(a_load_shows, cmd_i.out_load, out_valid_r, "loaded result not shown")
  `MLPR_ASSERT_NOW(a_pend_from_read, pend_valid_r, $past(cmd_i.rd_issue), "bit capture without row read")
  `MLPR_ASSERT_NEXT(a_decode_clears, cmd_i.decode, acc_r == '0 && !pend_valid_r, "column byte not cleared")

endmodule

@@ src/mono_lcd_page_report_builder_unit.sv @@
// top level of the monochrome lcd page report builder
// depends on mlpr_pkg, mlpr_ctrl and mlpr_dp
//
// input channel (in_valid / in_stall): a write request (opcode 0) stores
// in_image_byte at in_image_address of the row-major frame store; a read
// request (opcode 1) asks for report byte in_report_index.
// output channel (out_valid / out_stall): one result per read request,
// the report byte and an is_last flag for the final byte of the report.
// configuration: cfg_we with cfg_index 0 sets the report id, index 1 the
// pixel inversion; write only while no read is in flight.
// sequence: a write request is stored in the cycle it is accepted. a
// read of a header byte or past the report goes from decode to the
// output register; a pixel byte walks the eight rows of its page
// through the single read port of the frame store, one row a cycle,
// then a flush state; no request is taken until its result is loaded.
// a finished result sits in the output register; if the receiver stalls,
// the block waits with the next result until the register is free.
// reset clears the control state, the report id to 0 and sets inversion;
// the frame store is not cleared and must be written before it is read.
module mono_lcd_page_report_builder_unit #(
  parameter int PanelWidth  = 160,
  parameter int PanelHeight = 43,
  parameter int HeaderBytes = 32
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           in_opcode,
  input  logic [mlpr_pkg::ADDR_W-1:0]    in_image_address,
  input  logic [mlpr_pkg::BYTE_W-1:0]    in_image_byte,
  input  logic [mlpr_pkg::IDX_W-1:0]     in_report_index,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [mlpr_pkg::BYTE_W-1:0]    out_report_byte,
  output logic                           out_is_last,
  input  logic                           cfg_we,
  input  logic [mlpr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [mlpr_pkg::CFG_W-1:0]     cfg_data
);
  import mlpr_pkg::*;

  ctrl_cmd_t cmd;
  dp_sts_t   sts;

  mlpr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_opcode (in_opcode),
    .in_stall  (in_stall),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  mlpr_dp #(
    .PanelWidth  (PanelWidth),
    .PanelHeight (PanelHeight),
    .HeaderBytes (HeaderBytes)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_image_address (in_image_address),
    .in_image_byte    (in_image_byte),
    .in_report_index  (in_report_index),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_report_byte  (out_report_byte),
    .out_is_last      (out_is_last),
    .cmd_i            (cmd),
    .sts_o            (sts)
  );

endmodule

@@ sim/mono_lcd_page_report_builder_unit_tb.sv @@
// testbench for mono_lcd_page_report_builder_unit: directed table, then random write/read traffic
// results are checked against a predictor of the page report; depends on mlpr_pkg and the rtl
module mono_lcd_page_report_builder_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mlpr_pkg::*;

  localparam int PANEL_W      = 160;
  localparam int PANEL_H      = 43;
  localparam int HEADER_LEN   = 32;
  localparam int ROW_BYTES    = (PANEL_W + 7) / 8;
  localparam int PAGES        = (PANEL_H + 7) / 8;
  localparam int STORE_DEPTH  = PANEL_H * ROW_BYTES;
  localparam int REPORT_LEN   = HEADER_LEN + PAGES * PANEL_W;
  localparam int PHASE_ITEMS  = 285;
  localparam int LONG_HOLD    = 300;
  localparam int DRAIN_CYCLES = 16;
  localparam int LIMIT_NS     = 5_000_000;

  typedef struct packed {
    logic [BYTE_W-1:0] report_byte;
    logic              is_last;
  } page_result_t;

  typedef struct packed {
    logic              op;
    logic [ADDR_W-1:0] addr;
    logic [BYTE_W-1:0] data;
    logic [IDX_W-1:0]  idx;
    logic              typed;
    page_result_t      res;
  } dir_row_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic                 in_opcode = OP_WRITE;
  logic [ADDR_W-1:0]    in_image_address = '0;
  logic [BYTE_W-1:0]    in_image_byte = '0;
  logic [IDX_W-1:0]     in_report_index = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [BYTE_W-1:0]    out_report_byte;
  logic                 out_is_last;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_REPORT_ID;
  logic [CFG_W-1:0]     cfg_data = '0;

  // predictor copy of the frame store and registers
  logic [BYTE_W-1:0] img_mem [STORE_DEPTH];
  bit                img_written [STORE_DEPTH];
  logic [BYTE_W-1:0] id_reg = 8'h00;
  logic              inv_reg = 1'b1;

  page_result_t pending[$];
  int           err_cnt = 0;
  int           tx_idle_pct = 0;
  int           rx_stall_pct = 0;
  bit           pressure_go = 1'b0;
  logic         hold_on = 1'b0;

  // header and past-the-end read rows carry their result; pixel rows use the predictor
  dir_row_t dir_rows [25] = '{
    '{OP_READ,  10'd0,    8'h00, 10'd0,    1'b1, '{8'h00, 1'b0}},
    '{OP_READ,  10'd0,    8'h00, 10'd1,    1'b1, '{8'h00, 1'b0}},
    '{OP_READ,  10'd0,    8'h00, 10'd31,   1'b1, '{8'h00, 1'b0}},
    '{OP_READ,  10'd0,    8'h00, 10'd992,  1'b1, '{8'h00, 1'b0}},
    '{OP_READ,  10'd1023, 8'hFF, 10'd1023, 1'b1, '{8'h00, 1'b0}},
    '{OP_WRITE, 10'd1023, 8'hFF, 10'd0,    1'b0, '{8'h00, 1'b0}},
    '{OP_WRITE, 10'd860,  8'h55, 10'd0,    1'b0, '{8'h00, 1'b0}},
    '{OP_WRITE, 10'd0,    8'h80, 10'd0,    1'b0, '{8'h00, 1'b0}},
    '{OP_WRITE, 10'd20,   8'h00, 10'd0,    1'b0, '{8'h00, 1'b0}},
    '{OP_WRITE, 10'd40,   8'hFF, 10'd0,    1'b0, '{8'h00, 1'b0}},
    '{OP_WRITE, 10'd60,   8'h01, 10'd0,    1'b0, '{8'h00, 1'b0}},
    '{OP_WRITE, 10'd80,   8'h81, 10'd0,    1'b0, '{8'h00, 1'b0}},
    '{OP_WRITE, 10'd100,  8'h7F, 10'd0,    1'b0, '{8'h00, 1'b0}},
    '{OP_WRITE, 10'd120,  8'hFE, 10'd0,    1'b0, '{8'h00, 1'b0}},
    '{OP_WRITE, 10'd140,  8'h00, 10'd0,    1'b0, '{8'h00, 1'b0}},
    '{OP_READ,  10'd0,    8'h00, 10'd32,   1'b0, '{8'h00, 1'b0}},
    '{OP_READ,  10'd0,    8'h00, 10'd39,   1'b0, '{8'h00, 1'b0}},
    '{OP_WRITE, 10'd800,  8'hFF, 10'd0,    1'b0, '{8'h00, 1'b0}},
    '{OP_WRITE, 10'd820,  8'h00, 10'd0,    1'b0, '{8'h00, 1'b0}},
    '{OP_WRITE, 10'd840,  8'h80, 10'd0,    1'b0, '{8'h00, 1'b0}},
    '{OP_READ,  10'd0,    8'h00, 10'd832,  1'b0, '{8'h00, 1'b0}},
    '{OP_WRITE, 10'd819,  8'h01, 10'd0,    1'b0, '{8'h00, 1'b0}},
    '{OP_WRITE, 10'd839,  8'hFF, 10'd0,    1'b0, '{8'h00, 1'b0}},
    '{OP_WRITE, 10'd859,  8'h01, 10'd0,    1'b0, '{8'h00, 1'b0}},
    '{OP_READ,  10'd0,    8'h00, 10'd991,  1'b0, '{8'h00, 1'b0}}
  };

  mono_lcd_page_report_builder_unit dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_opcode        (in_opcode),
    .in_image_address (in_image_address),
    .in_image_byte    (in_image_byte),
    .in_report_index  (in_report_index),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_report_byte  (out_report_byte),
    .out_is_last      (out_is_last),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic page_result_t predict_report(logic [IDX_W-1:0] idx);
    page_result_t      r;
    int                pos;
    int                page;
    int                col;
    int                row;
    logic [BYTE_W-1:0] b;
    r.report_byte = '0;
    r.is_last = 1'b0;
    if (idx < REPORT_LEN) begin
      if (idx == 0) begin
        r.report_byte = id_reg;
      end else if (idx >= HEADER_LEN) begin
        pos = int'(idx) - HEADER_LEN;
        page = pos / PANEL_W;
        col = pos % PANEL_W;
        b = '0;
        // bit k of a column byte is row page*8+k; rows past the panel stay 0
        for (int k = 0; k < 8; k++) begin
          row = page * 8 + k;
          if (row < PANEL_H) b[k] = img_mem[row * ROW_BYTES + col / 8][7 - col % 8];
        end
        r.report_byte = inv_reg ? ~b : b;
      end
      r.is_last = (idx == REPORT_LEN - 1);
    end
    return r;
  endfunction

  // a pixel read is only issued once every store byte it gathers has been written
  function automatic bit rows_loaded(logic [IDX_W-1:0] idx);
    int pos;
    int page;
    int col;
    int row;
    bit ok;
    ok = 1'b1;
    if (idx >= HEADER_LEN && idx < REPORT_LEN) begin
      pos = int'(idx) - HEADER_LEN;
      page = pos / PANEL_W;
      col = pos % PANEL_W;
      for (int k = 0; k < 8; k++) begin
        row = page * 8 + k;
        if (row < PANEL_H && !img_written[row * ROW_BYTES + col / 8]) ok = 1'b0;
      end
    end
    return ok;
  endfunction

  function automatic void log_error(string msg);
    if (err_cnt < 10) $display("mismatch: %s", msg);
    err_cnt++;
  endfunction

  task automatic send_req(logic op, logic [ADDR_W-1:0] addr, logic [BYTE_W-1:0] data,
                          logic [IDX_W-1:0] idx, logic typed, page_result_t typed_res);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_opcode <= op;
    in_image_address <= addr;
    in_image_byte <= data;
    in_report_index <= idx;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (op == OP_WRITE) begin
      if (addr < STORE_DEPTH) begin
        img_mem[addr] = data;
        img_written[addr] = 1'b1;
      end
    end else begin
      pending.push_back(typed ? typed_res : predict_report(idx));
    end
  endtask

  task automatic random_phase();
    int                done;
    int                pick;
    int                page;
    int                grp;
    logic [IDX_W-1:0]  idx;
    logic [ADDR_W-1:0] addr;
    done = 0;
    while (done < PHASE_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        // load one byte column of a page, then read some of its columns back
        page = $urandom_range(0, PAGES - 1);
        grp = $urandom_range(0, ROW_BYTES - 1);
        for (int k = 0; k < 8; k++) begin
          if (page * 8 + k < PANEL_H) begin
            send_req(OP_WRITE, ADDR_W'((page * 8 + k) * ROW_BYTES + grp), BYTE_W'($urandom),
                     IDX_W'($urandom), 1'b0, '0);
            done++;
          end
        end
        repeat ($urandom_range(1, 4)) begin
          idx = IDX_W'(HEADER_LEN + page * PANEL_W + grp * 8 + $urandom_range(0, 7));
          send_req(OP_READ, ADDR_W'($urandom), BYTE_W'($urandom), idx, 1'b0, '0);
          done++;
        end
      end else if (pick < 70) begin
        idx = IDX_W'($urandom_range(0, REPORT_LEN - 1));
        if (!rows_loaded(idx)) idx = IDX_W'($urandom_range(0, HEADER_LEN - 1));
        send_req(OP_READ, ADDR_W'($urandom), BYTE_W'($urandom), idx, 1'b0, '0);
        done++;
      end else if (pick < 85) begin
        addr = ADDR_W'($urandom);
        send_req(OP_WRITE, addr, BYTE_W'($urandom), IDX_W'($urandom), 1'b0, '0);
        if (addr < STORE_DEPTH) done++;
      end else begin
        if ($urandom_range(0, 1) == 0) idx = IDX_W'($urandom_range(0, HEADER_LEN - 1));
        else idx = IDX_W'($urandom_range(REPORT_LEN, (1 << IDX_W) - 1));
        send_req(OP_READ, ADDR_W'($urandom), BYTE_W'($urandom), idx, 1'b0, '0);
        done++;
      end
    end
  endtask

  always @(posedge clk) begin
    out_stall <= hold_on || ($urandom_range(0, 99) < rx_stall_pct);
  end

  // long receiver hold-off so the output fills and the input backs up
  initial begin
    wait (pressure_go);
    @(posedge clk);
    hold_on <= 1'b1;
    repeat (LONG_HOLD) @(posedge clk);
    hold_on <= 1'b0;
  end

  always @(posedge clk) begin
    page_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending.size() == 0) begin
        log_error($sformatf("unexpected result byte %02h last %0b", out_report_byte,
                            out_is_last));
      end else begin
        want = pending.pop_front();
        if (out_report_byte !== want.report_byte)
          log_error($sformatf("report_byte expected %02h got %02h", want.report_byte,
                              out_report_byte));
        if (out_is_last !== want.is_last)
          log_error($sformatf("is_last expected %0b got %0b", want.is_last, out_is_last));
      end
    end
  end

  initial begin
    logic [BYTE_W-1:0] id;
    logic              inv;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (dir_rows[i]) begin
      send_req(dir_rows[i].op, dir_rows[i].addr, dir_rows[i].data, dir_rows[i].idx,
               dir_rows[i].typed, dir_rows[i].res);
    end
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          id = 8'hFF;
          inv = 1'b0;
        end
        1: begin
          id = 8'h00;
          inv = 1'b1;
        end
        2: begin
          id = BYTE_W'($urandom);
          inv = 1'b0;
        end
        default: begin
          id = BYTE_W'($urandom);
          inv = 1'b1;
        end
      endcase
      // registers change only once every read has drained
      in_valid <= 1'b0;
      while (pending.size() != 0) @(posedge clk);
      repeat (DRAIN_CYCLES) @(posedge clk);
      cfg_we <= 1'b1;
      cfg_index <= CFG_REPORT_ID;
      cfg_data <= id;
      @(posedge clk);
      cfg_index <= CFG_INVERT;
      cfg_data <= {(CFG_W - 1)'($urandom), inv};
      @(posedge clk);
      cfg_we <= 1'b0;
      id_reg = id;
      inv_reg = inv;
      case (ph)
        0: begin
          tx_idle_pct = 0;
          rx_stall_pct = 0;
          pressure_go = 1'b1;
        end
        1: begin
          tx_idle_pct = 76;
          rx_stall_pct = 0;
        end
        2: begin
          tx_idle_pct = 0;
          rx_stall_pct = 76;
        end
        default: begin
          tx_idle_pct = 15;
          rx_stall_pct = 15;
        end
      endcase
      random_phase();
    end
    in_valid <= 1'b0;
    while (pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_cnt == 0) begin
      $display("PASS mono_lcd_page_report_builder_unit");
    end else begin
      $display("FAIL mono_lcd_page_report_builder_unit");
    end
    $finish;
  end

  initial begin
    #(LIMIT_NS);
    $display("FAIL mono_lcd_page_report_builder_unit");
    $finish;
  end

endmodule
